// ===== hdl/ntp_response_evaluator_top_defines.svh =====
// Assertion macros for the SNTP response evaluator RTL.
// Included by modules that carry concurrent assertions; expects clk and rst_n in scope.
`ifndef NTP_RESPONSE_EVALUATOR_TOP_DEFINES_SVH
`define NTP_RESPONSE_EVALUATOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NRE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/nre_pkg.sv =====
// Shared types and constants for the SNTP response evaluator.
// No dependencies; imported by every module of the block.
package nre_pkg;

  localparam int IN_TDATA_W  = 344;
  localparam int OUT_TDATA_W = 248;

  localparam logic [1:0] OP_REQ   = 2'd0;
  localparam logic [1:0] OP_RESP  = 2'd1;
  localparam logic [1:0] OP_ROUND = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  localparam logic [1:0] LEAP_UNSYNC = 2'd3;

  localparam logic [3:0] ST_REQ_STORED = 4'd0;
  localparam logic [3:0] ST_BAD_SENDER = 4'd1;
  localparam logic [3:0] ST_UNSOLICIT  = 4'd2;
  localparam logic [3:0] ST_KOD_MARKED = 4'd3;
  localparam logic [3:0] ST_KOD_KILLED = 4'd4;
  localparam logic [3:0] ST_UNSYNC     = 4'd5;
  localparam logic [3:0] ST_ACCEPTED   = 4'd6;
  localparam logic [3:0] ST_NEW_BEST   = 4'd7;
  localparam logic [3:0] ST_NONE       = 4'd8;
  localparam logic [3:0] ST_RESULT     = 4'd9;

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  srv_idx;
    logic [63:0] local_stamp;
    logic [63:0] origin_stamp;
    logic [63:0] receive_stamp;
    logic [63:0] transmit_stamp;
    logic [1:0]  leap;
    logic [7:0]  stratum;
    logic [31:0] rt_delay;
    logic [31:0] rt_disp;
    logic        refid_deny;
    logic        sender_ok;
  } item_t;

  typedef struct packed {
    item_t       item;
    logic [63:0] offset;
    logic [31:0] delay;
    logic [31:0] maxerr;
    logic [31:0] metric;
    logic [31:0] metric_disc;
  } calc_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [63:0] offset;
    logic [31:0] delay_out;
    logic [31:0] root_maxerr_out;
    logic [31:0] root_delay_out;
    logic [31:0] root_disp_out;
    logic [4:0]  best_server;
    logic [7:0]  stratum_out;
    logic [1:0]  leap_out;
    logic [1:0]  pending_leap_out;
    logic [31:0] skip_mask;
  } result_t;

endpackage

// ===== hdl/nre_arith.sv =====
// Timestamp arithmetic stage: offset, delay, root max error and metrics, registered.
// Depends on nre_pkg.
module nre_arith import nre_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output calc_t out_calc
);

  function automatic logic [63:0] half_trunc(input logic [63:0] x);
    logic [63:0] sh;
    sh = {x[63], x[63:1]};
    return sh + {63'd0, x[63] & x[0]};
  endfunction

  logic        valid_r;
  calc_t       calc_r;
  calc_t       calc_nxt;
  logic [63:0] d21;
  logic [63:0] d34;
  logic [63:0] d41;
  logic [63:0] d32;
  logic [63:0] dly;
  logic [31:0] metric;

  always_comb begin
    d21 = in_item.receive_stamp - in_item.origin_stamp;
    d34 = in_item.transmit_stamp - in_item.local_stamp;
    d41 = in_item.local_stamp - in_item.origin_stamp;
    d32 = in_item.transmit_stamp - in_item.receive_stamp;
    dly = d41 - d32;
    calc_nxt.item   = in_item;
    calc_nxt.offset = half_trunc(d21) + half_trunc(d34);
    calc_nxt.delay  = dly[47:16];
    calc_nxt.maxerr = in_item.rt_disp + {1'b0, in_item.rt_delay[31:1]};
    metric = {in_item.rt_delay[30:0], 1'b0} + dly[47:16];
    calc_nxt.metric      = metric;
    calc_nxt.metric_disc = metric - {2'b00, metric[31:2]};
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_calc  = calc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      calc_r <= calc_nxt;
    end
  end

endmodule

// ===== hdl/nre_eval.sv =====
// Evaluation stage: cookie, kiss-of-death masks, best-response state and result register.
// Depends on nre_pkg and the assertion macro header.
`include "ntp_response_evaluator_top_defines.svh"
module nre_eval import nre_pkg::*; #(
  parameter int SERVERS = 32
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  calc_t   in_calc,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic [63:0]        cookie_r, cookie_nxt;
  logic [4:0]         cs_r, cs_nxt;
  logic [SERVERS-1:0] kod_r, kod_nxt;
  logic [SERVERS-1:0] killed_r, killed_nxt;
  logic [4:0]         lb_r, lb_nxt;
  logic               lbv_r, lbv_nxt;
  logic [7:0]         bstrat_r, bstrat_nxt;
  logic [1:0]         pleap_r, pleap_nxt;
  logic [31:0]        bmetric_r, bmetric_nxt;
  logic [63:0]        boff_r, boff_nxt;
  logic [31:0]        bdelay_r, bdelay_nxt;
  logic [31:0]        bmaxerr_r, bmaxerr_nxt;
  logic [31:0]        brdel_r, brdel_nxt;
  logic [31:0]        brdis_r, brdis_nxt;
  logic [4:0]         bidx_r, bidx_nxt;
  logic [1:0]         bleap_r, bleap_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            res_r, res_nxt;
  logic [SERVERS-1:0] srv_bit;
  logic               killed_hit;
  logic               kod_hit;
  logic [31:0]        metric;
  logic               fire;
  logic               best_clear;
  item_t              it;

  assign it       = in_calc.item;
  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    for (int i = 0; i < SERVERS; i++) begin
      srv_bit[i] = (cs_r == 5'(i));
    end
  end

  assign killed_hit = |(killed_r & srv_bit);
  assign kod_hit    = |(kod_r & srv_bit);
  assign metric     = (lbv_r && lb_r == cs_r) ? in_calc.metric_disc : in_calc.metric;

  always_comb begin
    cookie_nxt  = cookie_r;
    cs_nxt      = cs_r;
    kod_nxt     = kod_r;
    killed_nxt  = killed_r;
    lb_nxt      = lb_r;
    lbv_nxt     = lbv_r;
    bstrat_nxt  = bstrat_r;
    pleap_nxt   = pleap_r;
    bmetric_nxt = bmetric_r;
    boff_nxt    = boff_r;
    bdelay_nxt  = bdelay_r;
    bmaxerr_nxt = bmaxerr_r;
    brdel_nxt   = brdel_r;
    brdis_nxt   = brdis_r;
    bidx_nxt    = bidx_r;
    bleap_nxt   = bleap_r;
    res_nxt     = '0;
    case (it.op)
      OP_REQ: begin
        cookie_nxt     = it.local_stamp;
        cs_nxt         = it.srv_idx;
        res_nxt.status = ST_REQ_STORED;
      end
      OP_RESP: begin
        if (!it.sender_ok || killed_hit) begin
          res_nxt.status = ST_BAD_SENDER;
        end else if (it.origin_stamp != cookie_r) begin
          res_nxt.status = ST_UNSOLICIT;
        end else if (it.leap == LEAP_UNSYNC) begin
          if (!it.refid_deny) begin
            res_nxt.status = ST_UNSYNC;
          end else if (kod_hit) begin
            killed_nxt     = killed_r | srv_bit;
            res_nxt.status = ST_KOD_KILLED;
          end else begin
            kod_nxt        = kod_r | srv_bit;
            res_nxt.status = ST_KOD_MARKED;
          end
        end else begin
          kod_nxt = kod_r & ~srv_bit;
          if (it.leap != 2'd0) begin
            pleap_nxt = it.leap;
          end
          if (bstrat_r == 8'd0 || metric < bmetric_r) begin
            bmetric_nxt    = metric;
            boff_nxt       = in_calc.offset;
            bdelay_nxt     = in_calc.delay;
            bmaxerr_nxt    = in_calc.maxerr;
            brdel_nxt      = it.rt_delay;
            brdis_nxt      = it.rt_disp;
            bidx_nxt       = cs_r;
            bstrat_nxt     = it.stratum;
            bleap_nxt      = it.leap;
            res_nxt.status = ST_NEW_BEST;
          end else begin
            res_nxt.status = ST_ACCEPTED;
          end
        end
      end
      OP_ROUND: begin
        if (bstrat_r == 8'd0) begin
          res_nxt.status = ST_NONE;
        end else begin
          res_nxt.status          = ST_RESULT;
          res_nxt.offset          = boff_r;
          res_nxt.delay_out       = bdelay_r;
          res_nxt.root_maxerr_out = bmaxerr_r;
          res_nxt.root_delay_out  = brdel_r;
          res_nxt.root_disp_out   = brdis_r;
          res_nxt.best_server     = bidx_r;
          res_nxt.stratum_out     = bstrat_r;
          res_nxt.leap_out        = bleap_r;
          lb_nxt                  = bidx_r;
          lbv_nxt                 = 1'b1;
        end
        kod_nxt     = '0;
        bstrat_nxt  = '0;
        bmetric_nxt = '0;
        boff_nxt    = '0;
        bdelay_nxt  = '0;
        bmaxerr_nxt = '0;
        brdel_nxt   = '0;
        brdis_nxt   = '0;
        bidx_nxt    = '0;
        bleap_nxt   = '0;
      end
      default: begin
        res_nxt.status = ST_REQ_STORED;
      end
    endcase
    res_nxt.pending_leap_out = pleap_nxt;
    res_nxt.skip_mask        = 32'(kod_nxt | killed_nxt);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = (it.op != OP_RSVD);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cookie_r    <= '0;
      cs_r        <= '0;
      kod_r       <= '0;
      killed_r    <= '0;
      lb_r        <= '0;
      lbv_r       <= 1'b0;
      bstrat_r    <= '0;
      pleap_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        cookie_r <= cookie_nxt;
        cs_r     <= cs_nxt;
        kod_r    <= kod_nxt;
        killed_r <= killed_nxt;
        lb_r     <= lb_nxt;
        lbv_r    <= lbv_nxt;
        bstrat_r <= bstrat_nxt;
        pleap_r  <= pleap_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      bmetric_r <= bmetric_nxt;
      boff_r    <= boff_nxt;
      bdelay_r  <= bdelay_nxt;
      bmaxerr_r <= bmaxerr_nxt;
      brdel_r   <= brdel_nxt;
      brdis_r   <= brdis_nxt;
      bidx_r    <= bidx_nxt;
      bleap_r   <= bleap_nxt;
      res_r     <= res_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_res    = res_r;
  assign best_clear = res_r.offset == '0 && res_r.best_server == '0 && res_r.stratum_out == '0;

  `NRE_ASSERT_NEXT(a_result_issued, fire && it.op != OP_RSVD, out_valid_r, "result not issued")
  `NRE_ASSERT_NEXT(a_round_clears_kod, fire && it.op == OP_ROUND, kod_r == '0, "kod not cleared")
  `NRE_ASSERT_NEXT(a_killed_sticky, 1'b1, (killed_r | $past(killed_r)) == killed_r, "kill lost")
  `NRE_ASSERT_NOW(a_fields_only_result, out_valid_r && res_r.status != ST_RESULT, best_clear, "best fields leaked")

endmodule

// ===== hdl/ntp_response_evaluator_top.sv =====
// Top level of the SNTP response evaluator: stream ports, input register and stage wiring.
// Depends on nre_pkg, nre_arith and nre_eval.
//
//   channel | direction | tdata                         | tuser
//   in_     | slave     | response / request fields     | op
//   out_    | master    | best result, leap, skip mask  | status
//
// One item is taken per cycle unless the output stalls. The three register stages
// (input, arithmetic, result) each hold one item and fill bubbles independently, so
// input is still taken while a result waits to be collected, until the stages fill.
// Synchronous active-low reset clears the stage valid flags and the protocol state.
// Op 3 items are consumed and produce no transfer on the output.
module ntp_response_evaluator_top import nre_pkg::*; #(
  parameter int SERVERS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // server index, local_stamp, origin_stamp, receive_stamp, transmit_stamp, leap,
  // stratum, root delay, root dispersion, refid_deny, sender_ok, zero padding
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // op
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // offset, delay_out, root_maxerr_out, root_delay_out, root_disp_out, best_server,
  // stratum_out, leap_out, pending_leap_out, skip_mask, zero padding
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // status
  output logic [3:0]             out_tuser
);

  item_t   in_item;
  item_t   in_r;
  logic    in_valid_r;
  logic    arith_ready;
  logic    calc_valid;
  calc_t   calc;
  logic    eval_ready;
  result_t res;

  always_comb begin
    in_item.op             = in_tuser;
    in_item.srv_idx        = in_tdata[4:0];
    in_item.local_stamp    = in_tdata[68:5];
    in_item.origin_stamp   = in_tdata[132:69];
    in_item.receive_stamp  = in_tdata[196:133];
    in_item.transmit_stamp = in_tdata[260:197];
    in_item.leap           = in_tdata[262:261];
    in_item.stratum        = in_tdata[270:263];
    in_item.rt_delay       = in_tdata[302:271];
    in_item.rt_disp        = in_tdata[334:303];
    in_item.refid_deny     = in_tdata[335];
    in_item.sender_ok      = in_tdata[336];
  end

  assign in_tready = !in_valid_r || arith_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_r <= in_item;
    end
  end

  nre_arith u_arith (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid_r),
    .in_item   (in_r),
    .in_ready  (arith_ready),
    .out_valid (calc_valid),
    .out_ready (eval_ready),
    .out_calc  (calc)
  );

  nre_eval #(
    .SERVERS (SERVERS)
  ) u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (calc_valid),
    .in_calc   (calc),
    .in_ready  (eval_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tuser = res.status;
  assign out_tdata = {7'd0, res.skip_mask, res.pending_leap_out, res.leap_out,
                      res.stratum_out, res.best_server, res.root_disp_out,
                      res.root_delay_out, res.root_maxerr_out, res.delay_out, res.offset};

endmodule

// ===== tb/ntp_response_evaluator_top_test.sv =====
// Self-checking testbench for the SNTP response evaluator: request, response and round-end
// transfers are driven on the input stream and every result is checked against a model.
// Depends on nre_pkg and the ntp_response_evaluator_top RTL.
module ntp_response_evaluator_top_test import nre_pkg::*; ();

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 800;

  class sntp_best_tracker;
    logic [63:0] cookie;
    logic [4:0]  cur_server;
    logic [31:0] kod_mask;
    logic [31:0] killed_mask;
    logic [4:0]  prev_best;
    logic        prev_best_valid;
    logic [7:0]  best_stratum;
    logic [31:0] best_metric;
    logic [63:0] best_offset;
    logic [31:0] best_delay;
    logic [31:0] best_maxerr;
    logic [31:0] best_rdelay;
    logic [31:0] best_rdisp;
    logic [4:0]  best_index;
    logic [1:0]  best_leap;
    logic [1:0]  noted_leap;
    result_t     awaited_reports[$];
    int          mismatches;

    function new();
      cookie = '0;
      cur_server = '0;
      kod_mask = '0;
      killed_mask = '0;
      prev_best = '0;
      prev_best_valid = 1'b0;
      noted_leap = '0;
      mismatches = 0;
      forget_best();
    endfunction

    function void forget_best();
      best_stratum = '0;
      best_metric = '0;
      best_offset = '0;
      best_delay = '0;
      best_maxerr = '0;
      best_rdelay = '0;
      best_rdisp = '0;
      best_index = '0;
      best_leap = '0;
    endfunction

    function void note_transfer(item_t it);
      result_t rep;
      logic [31:0] srv_mask;
      logic signed [63:0] fwd;
      logic signed [63:0] back;
      logic [63:0] rtt;
      logic [63:0] off;
      logic [31:0] dly;
      logic [31:0] maxerr;
      logic [31:0] metric;
      if (it.op == OP_RSVD) return;
      rep = '0;
      srv_mask = 32'd1 << cur_server;
      case (it.op)
        OP_REQ: begin
          cookie = it.local_stamp;
          cur_server = it.srv_idx;
          rep.status = ST_REQ_STORED;
        end
        OP_RESP: begin
          if (!it.sender_ok || (killed_mask & srv_mask) != 0) begin
            rep.status = ST_BAD_SENDER;
          end else if (it.origin_stamp != cookie) begin
            rep.status = ST_UNSOLICIT;
          end else if (it.leap == LEAP_UNSYNC) begin
            if (!it.refid_deny) begin
              rep.status = ST_UNSYNC;
            end else if ((kod_mask & srv_mask) != 0) begin
              killed_mask |= srv_mask;
              rep.status = ST_KOD_KILLED;
            end else begin
              kod_mask |= srv_mask;
              rep.status = ST_KOD_MARKED;
            end
          end else begin
            kod_mask &= ~srv_mask;
            if (it.leap != 2'd0) noted_leap = it.leap;
            fwd = it.receive_stamp - it.origin_stamp;
            back = it.transmit_stamp - it.local_stamp;
            off = (fwd / 64'sd2) + (back / 64'sd2);
            rtt = (it.local_stamp - it.origin_stamp) - (it.transmit_stamp - it.receive_stamp);
            dly = rtt[47:16];
            maxerr = it.rt_disp + (it.rt_delay >> 1);
            metric = (it.rt_delay << 1) + dly;
            if (prev_best_valid && prev_best == cur_server) metric = metric - (metric >> 2);
            if (best_stratum == 8'd0 || metric < best_metric) begin
              best_metric = metric;
              best_offset = off;
              best_delay = dly;
              best_maxerr = maxerr;
              best_rdelay = it.rt_delay;
              best_rdisp = it.rt_disp;
              best_index = cur_server;
              best_stratum = it.stratum;
              best_leap = it.leap;
              rep.status = ST_NEW_BEST;
            end else begin
              rep.status = ST_ACCEPTED;
            end
          end
        end
        default: begin
          if (best_stratum == 8'd0) begin
            rep.status = ST_NONE;
          end else begin
            rep.status = ST_RESULT;
            rep.offset = best_offset;
            rep.delay_out = best_delay;
            rep.root_maxerr_out = best_maxerr;
            rep.root_delay_out = best_rdelay;
            rep.root_disp_out = best_rdisp;
            rep.best_server = best_index;
            rep.stratum_out = best_stratum;
            rep.leap_out = best_leap;
            prev_best = best_index;
            prev_best_valid = 1'b1;
          end
          kod_mask = '0;
          forget_best();
        end
      endcase
      rep.pending_leap_out = noted_leap;
      rep.skip_mask = kod_mask | killed_mask;
      awaited_reports.push_back(rep);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch in %s: expected %h, got %h", name, want, got);
      end
    endfunction

    function void check_report(result_t got);
      result_t want;
      if (awaited_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with status %0d arrived unexpectedly", got.status);
        return;
      end
      want = awaited_reports.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("offset", want.offset, got.offset);
      compare_field("delay_out", want.delay_out, got.delay_out);
      compare_field("root_maxerr_out", want.root_maxerr_out, got.root_maxerr_out);
      compare_field("root_delay_out", want.root_delay_out, got.root_delay_out);
      compare_field("root_disp_out", want.root_disp_out, got.root_disp_out);
      compare_field("best_server", want.best_server, got.best_server);
      compare_field("stratum_out", want.stratum_out, got.stratum_out);
      compare_field("leap_out", want.leap_out, got.leap_out);
      compare_field("pending_leap_out", want.pending_leap_out, got.pending_leap_out);
      compare_field("skip_mask", want.skip_mask, got.skip_mask);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]             in_tuser = OP_REQ;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [3:0]             out_tuser;

  sntp_best_tracker tracker = new();
  bit  calm = 1'b0;
  bit  hold_trigger = 1'b0;
  int  hold_count = 0;
  int  cycles = 0;
  int  items_sent = 0;

  ntp_response_evaluator_top #(.SERVERS(32)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [IN_TDATA_W-1:0] pack_item(item_t it);
    return {7'd0, it.sender_ok, it.refid_deny, it.rt_disp, it.rt_delay, it.stratum,
            it.leap, it.transmit_stamp, it.receive_stamp, it.origin_stamp, it.local_stamp,
            it.srv_idx};
  endfunction

  function automatic item_t unpack_item(logic [IN_TDATA_W-1:0] d, logic [1:0] op);
    item_t it;
    it.op = op;
    {it.sender_ok, it.refid_deny, it.rt_disp, it.rt_delay, it.stratum, it.leap,
     it.transmit_stamp, it.receive_stamp, it.origin_stamp, it.local_stamp,
     it.srv_idx} = d[336:0];
    return it;
  endfunction

  function automatic result_t unpack_report(logic [OUT_TDATA_W-1:0] d, logic [3:0] status);
    result_t r;
    r.status = status;
    {r.skip_mask, r.pending_leap_out, r.leap_out, r.stratum_out, r.best_server,
     r.root_disp_out, r.root_delay_out, r.root_maxerr_out, r.delay_out, r.offset} = d[240:0];
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_span();
    logic [31:0] r;
    int pick;
    r = $urandom;
    pick = $urandom_range(99);
    if (pick < 45) return {{32{r[31]}}, r};
    if (pick < 90) return {48'd0, r[15:0]};
    return rand64();
  endfunction

  function automatic item_t make_request(logic [4:0] srv, logic [63:0] ck);
    item_t it;
    logic [351:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom};
    it = noise[$bits(item_t)-1:0];
    it.op = OP_REQ;
    it.srv_idx = srv;
    it.local_stamp = ck;
    return it;
  endfunction

  function automatic item_t make_response(logic [63:0] t1, logic [1:0] li, logic deny,
                                          logic ok);
    item_t it;
    it.op = OP_RESP;
    it.srv_idx = 5'($urandom_range(31));
    it.origin_stamp = t1;
    it.receive_stamp = t1 + rand_span();
    it.transmit_stamp = it.receive_stamp + {48'd0, 16'($urandom)};
    it.local_stamp = it.transmit_stamp + rand_span();
    it.leap = li;
    it.stratum = ($urandom_range(99) < 5) ? 8'($urandom) : 8'($urandom_range(1, 15));
    it.rt_delay = ($urandom_range(1) == 1) ? $urandom : $urandom_range(0, 200000);
    it.rt_disp = ($urandom_range(1) == 1) ? $urandom : $urandom_range(0, 200000);
    it.refid_deny = deny;
    it.sender_ok = ok;
    return it;
  endfunction

  function automatic item_t make_op(logic [1:0] op);
    item_t it;
    it = make_response(rand64(), 2'($urandom), 1'($urandom), 1'($urandom));
    it.op = op;
    return it;
  endfunction

  task automatic send_item(input item_t it);
    if (!calm && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= pack_item(it);
    in_tuser <= it.op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (it.op != OP_RSVD) items_sent++;
  endtask

  task automatic wait_drained();
    while (tracker.awaited_reports.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_directed();
    item_t it;
    logic [63:0] ck;
    send_item(make_op(OP_ROUND));
    send_item(make_op(OP_RSVD));
    ck = 64'hFFFF_FFFF_FFFF_FFFF;
    send_item(make_request(5'd0, ck));
    send_item(make_response(ck, 2'd0, 1'b0, 1'b0));
    send_item(make_response(~ck, 2'd0, 1'b0, 1'b1));
    send_item(make_response(ck, LEAP_UNSYNC, 1'b0, 1'b1));
    send_item(make_response(ck, LEAP_UNSYNC, 1'b1, 1'b1));
    it = make_response(ck, 2'd1, 1'b0, 1'b1);
    it.local_stamp = 64'd0;
    it.receive_stamp = 64'hFFFF_FFFF_FFFF_FFFF;
    it.transmit_stamp = 64'h8000_0000_0000_0000;
    it.rt_delay = 32'hFFFF_FFFF;
    it.rt_disp = 32'hFFFF_FFFF;
    it.stratum = 8'hFF;
    send_item(it);
    send_item(make_response(ck, 2'd2, 1'b0, 1'b1));
    send_item(make_op(OP_ROUND));
    ck = 64'd0;
    send_item(make_request(5'd0, ck));
    it = make_response(ck, 2'd0, 1'b0, 1'b1);
    it.local_stamp = 64'd0;
    it.receive_stamp = 64'd0;
    it.transmit_stamp = 64'd0;
    it.rt_delay = 32'd0;
    it.rt_disp = 32'd0;
    send_item(it);
    ck = 64'h0123_4567_89AB_CDEF;
    send_item(make_request(5'd5, ck));
    send_item(make_response(ck, LEAP_UNSYNC, 1'b1, 1'b1));
    send_item(make_response(ck, LEAP_UNSYNC, 1'b1, 1'b1));
    send_item(make_response(ck, 2'd0, 1'b0, 1'b1));
    send_item(make_op(OP_ROUND));
    ck = 64'h8000_0000_0000_0001;
    send_item(make_request(5'd31, ck));
    it = make_response(ck, 2'd0, 1'b0, 1'b1);
    it.stratum = 8'd0;
    send_item(it);
    send_item(make_op(OP_ROUND));
    send_item(make_op(OP_RSVD));
  endtask

  task automatic run_random();
    logic [63:0] ck;
    logic [4:0]  srv;
    logic [1:0]  li;
    logic        deny;
    item_t       it;
    int          exchanges;
    int          replies;
    while (items_sent < RANDOM_ITEMS) begin
      exchanges = $urandom_range(1, 6);
      for (int e = 0; e < exchanges; e++) begin
        srv = ($urandom_range(99) < 80) ? 5'($urandom_range(0, 7)) : 5'($urandom);
        ck = rand64();
        send_item(make_request(srv, ck));
        replies = ($urandom_range(99) < 75) ? 1 : $urandom_range(2, 3);
        for (int r = 0; r < replies; r++) begin
          li = ($urandom_range(99) < 15) ? LEAP_UNSYNC : 2'($urandom_range(0, 2));
          deny = ($urandom_range(99) < 60);
          it = make_response(ck, li, deny, $urandom_range(99) < 92);
          if ($urandom_range(99) < 8) it.origin_stamp = ck ^ (64'd1 << $urandom_range(63));
          send_item(it);
          if ($urandom_range(99) < 5)
            send_item(make_op(($urandom_range(1) == 1) ? OP_RESP : OP_RSVD));
        end
        if (items_sent >= 100 && items_sent < 110) hold_trigger = 1'b1;
        calm = (items_sent >= 400 && items_sent < 520);
      end
      send_item(make_op(OP_ROUND));
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_count > 0) begin
      hold_count--;
      out_tready <= 1'b0;
    end else if (hold_trigger) begin
      hold_trigger = 1'b0;
      hold_count = 120;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 23);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) tracker.note_transfer(unpack_item(in_tdata, in_tuser));
      if (out_tvalid && out_tready) tracker.check_report(unpack_report(out_tdata, out_tuser));
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("ntp_response_evaluator_top_test: errors");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    in_tvalid <= 1'b0;
    wait_drained();
    run_random();
    in_tvalid <= 1'b0;
    wait_drained();
    if (tracker.mismatches == 0 && tracker.awaited_reports.size() == 0) begin
      $display("ntp_response_evaluator_top_test: clean");
    end else begin
      $display("ntp_response_evaluator_top_test: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/nre_pkg.sv
hdl/nre_arith.sv
hdl/nre_eval.sv
hdl/ntp_response_evaluator_top.sv
tb/ntp_response_evaluator_top_test.sv
